// ----- rtl/core/pteb_pkg.sv -----
// ----------------------------------------------------------------------------
// pteb_pkg
// shared constants, codes and controller/datapath types of the tdc hit
// event builder
// ----------------------------------------------------------------------------
package pteb_pkg;

  // sizing
  localparam int NUM_DETECTORS = 32;
  localparam int RAW_BITS      = 16;
  localparam int NUM_CHANNELS  = 5;
  localparam int GAIN_W        = 24;
  localparam int TIME_W        = 32;
  localparam int PROD_W        = RAW_BITS + GAIN_W;
  localparam int NUM_SLOTS     = NUM_DETECTORS * NUM_CHANNELS;
  localparam int DET_W         = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
  localparam int SLOT_W        = $clog2(NUM_SLOTS);
  localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
  // the scan covers at most the 32 detectors a 5-bit id can name
  localparam int SCAN_LAST     = ((NUM_DETECTORS < 32) ? NUM_DETECTORS : 32) - 1;

  // request codes
  localparam logic [1:0] REQ_HIT   = 2'd0;
  localparam logic [1:0] REQ_EOE   = 2'd1;
  localparam logic [1:0] REQ_TABLE = 2'd2;

  // table words
  localparam logic [2:0] TW_LOW       = 3'd0;
  localparam logic [2:0] TW_HIGH      = 3'd1;
  localparam logic [2:0] TW_GAIN_X1   = 3'd2;
  localparam logic [2:0] TW_GAIN_LAST = 3'd6;

  // channel codes
  localparam logic [2:0] CH_X1 = 3'd0;
  localparam logic [2:0] CH_X2 = 3'd1;
  localparam logic [2:0] CH_Y1 = 3'd2;
  localparam logic [2:0] CH_Y2 = 3'd3;
  localparam logic [2:0] CH_A  = 3'd4;

  // marker for a difference or sum with a missing input
  localparam logic [32:0] MISSING_33 = 33'(-99999);
  localparam logic [33:0] MISSING_34 = 34'(-99999);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT,
    ST_SCAN,
    ST_EMIT_MID,
    ST_READ,
    ST_DRAIN,
    ST_CALC,
    ST_EMIT_LAST
  } ctrl_state_t;

  typedef struct packed {
    logic take;         // request word accepted this cycle
    logic hit_commit;   // write the scaled hit and its present bit
    logic scan_start;   // detector counter to zero
    logic scan_next;    // detector counter up by one
    logic rd_issue;     // read one stored time of the current detector
    logic calc;         // form the result of the current detector
    logic load_out;     // move the held result to the output register
    logic out_last;     // last flag for that move
    logic clr_present;  // end of event: drop all present bits
  } pteb_cmd_t;

  typedef struct packed {
    logic mask_nz;      // current detector holds a hit
    logic scan_end;     // current detector is the last one scanned
    logic rd_end;       // last channel read issued this cycle
    logic out_free;     // output register can take a word this cycle
  } pteb_stat_t;

endpackage

// ----- rtl/core/pteb_ctrl.sv -----
// ----------------------------------------------------------------------------
// pteb_ctrl
// state machine sequencing hits, table writes and the end-of-event scan
// ----------------------------------------------------------------------------
module pteb_ctrl
  import pteb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  output logic       req_stall,
  input  pteb_stat_t stat,
  output pteb_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        have_res, have_res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      have_res <= 1'b0;
    end else begin
      state    <= state_next;
      have_res <= have_res_next;
    end
  end

  always_comb begin
    state_next    = state;
    have_res_next = have_res;
    cmd           = '0;
    req_stall     = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.take = 1'b1;
          if (req_type == REQ_HIT) begin
            state_next = ST_HIT;
          end else if (req_type == REQ_EOE) begin
            cmd.scan_start = 1'b1;
            have_res_next  = 1'b0;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_HIT: begin
        cmd.hit_commit = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.mask_nz) begin
          state_next = have_res ? ST_EMIT_MID : ST_READ;
        end else if (stat.scan_end) begin
          if (have_res) begin
            state_next = ST_EMIT_LAST;
          end else begin
            cmd.clr_present = 1'b1;
            state_next      = ST_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_EMIT_MID: begin
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          have_res_next = 1'b0;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        if (stat.rd_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc      = 1'b1;
        have_res_next = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_EMIT_LAST;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_EMIT_LAST: begin
        if (stat.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.clr_present = 1'b1;
          have_res_next   = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/pteb_dpath.sv -----
// ----------------------------------------------------------------------------
// pteb_dpath
// calibration tables, hit store, gain multiplier, result arithmetic and
// output register
// ----------------------------------------------------------------------------
module pteb_dpath
  import pteb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  pteb_cmd_t           cmd,
  output pteb_stat_t          stat,
  input  logic [1:0]          req_type,
  input  logic [4:0]          det_id,
  input  logic [2:0]          channel,
  input  logic [15:0]         raw_time,
  input  logic [2:0]          table_word,
  input  logic [23:0]         table_value,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [4:0]          out_det,
  output logic [4:0]          present_mask,
  output logic [31:0]         time_x1,
  output logic [31:0]         time_x2,
  output logic [31:0]         time_y1,
  output logic [31:0]         time_y2,
  output logic [31:0]         time_anode,
  output logic signed [32:0]  diff_x,
  output logic signed [33:0]  sum_x,
  output logic signed [32:0]  diff_y,
  output logic signed [33:0]  sum_y,
  output logic                last
);

  // calibration tables
  logic [RAW_BITS-1:0]        win_low  [NUM_DETECTORS];
  logic [RAW_BITS-1:0]        win_high [NUM_DETECTORS];
  logic [GAIN_W-1:0]          gain_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       gain_vld;

  // hit store
  logic [TIME_W-1:0]          time_mem [NUM_SLOTS];
  logic [NUM_CHANNELS-1:0]    present  [NUM_DETECTORS];

  // accept-side decode
  logic [DET_W-1:0]           det_idx;
  logic                       det_ok;
  logic                       ch_ok;
  logic [RAW_BITS-1:0]        raw_k;
  logic [NUM_CHANNELS-1:0]    ch_onehot;
  logic                       in_win;
  logic                       hit_keep_in;
  logic [SLOT_W-1:0]          slot_hit;
  logic [SLOT_W-1:0]          slot_tab;
  logic                       tab_wr;

  // hit pipeline
  logic                       hit_keep;
  logic [SLOT_W-1:0]          hit_slot;
  logic [DET_W-1:0]           hit_det;
  logic [NUM_CHANNELS-1:0]    hit_onehot;
  logic [RAW_BITS-1:0]        hit_raw;
  logic [GAIN_W-1:0]          gain_rd;
  logic                       gain_ok;
  logic [PROD_W-1:0]          prod;
  logic [63:0]                scaled;
  logic [TIME_W-1:0]          time_sat;

  // scan
  logic [DET_W-1:0]           scan_d;
  logic [CH_IDX_W-1:0]        rd_c;
  logic [SLOT_W-1:0]          rd_addr;
  logic [TIME_W-1:0]          time_rd;
  logic                       cap_vld;
  logic [CH_IDX_W-1:0]        cap_idx;
  logic [TIME_W-1:0]          tbuf [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]    mask_cur;

  // held result
  logic [TIME_W-1:0]          t_x1, t_x2, t_y1, t_y2, t_a;
  logic                       hx, hy, ha;
  logic [4:0]                 r_det;
  logic [4:0]                 r_mask;
  logic [TIME_W-1:0]          r_x1, r_x2, r_y1, r_y2, r_a;
  logic [32:0]                r_diff_x, r_diff_y;
  logic [33:0]                r_sum_x, r_sum_y;

  // ---- accept-side decode
  assign det_idx     = DET_W'(det_id);
  assign det_ok      = 32'(det_id) < NUM_DETECTORS;
  assign ch_ok       = 32'(channel) < NUM_CHANNELS;
  assign raw_k       = RAW_BITS'(raw_time);
  assign ch_onehot   = NUM_CHANNELS'(1) << channel;
  assign in_win      = (raw_k > win_low[det_idx]) && (raw_k < win_high[det_idx]);
  assign hit_keep_in = (req_type == REQ_HIT) && det_ok && ch_ok && in_win &&
                       ((present[det_idx] & ch_onehot) == '0);
  assign slot_hit    = SLOT_W'(int'(det_idx) * NUM_CHANNELS + int'(channel));
  assign slot_tab    = SLOT_W'(int'(det_idx) * NUM_CHANNELS + int'(table_word) -
                              int'(TW_GAIN_X1));
  assign tab_wr      = cmd.take && (req_type == REQ_TABLE) && det_ok;

  // window limits, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DETECTORS; i++) begin
        win_low[i]  <= '0;
        win_high[i] <= '0;
      end
    end else if (tab_wr) begin
      if (table_word == TW_LOW) begin
        win_low[det_idx] <= RAW_BITS'(table_value);
      end else if (table_word == TW_HIGH) begin
        win_high[det_idx] <= RAW_BITS'(table_value);
      end
    end
  end

  // gain memory: a slot without its valid bit reads as zero gain
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_vld <= '0;
    end else if (tab_wr && table_word >= TW_GAIN_X1 && table_word <= TW_GAIN_LAST) begin
      gain_vld[slot_tab] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_wr && table_word >= TW_GAIN_X1 && table_word <= TW_GAIN_LAST) begin
      gain_mem[slot_tab] <= table_value;
    end
    if (cmd.take) begin
      gain_rd <= gain_mem[slot_hit];
    end
  end

  // ---- hit pipeline
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hit_keep   <= hit_keep_in;
      hit_slot   <= slot_hit;
      hit_det    <= det_idx;
      hit_onehot <= ch_onehot;
      hit_raw    <= raw_k;
      gain_ok    <= gain_vld[slot_hit];
    end
  end

  assign prod     = PROD_W'(hit_raw) * PROD_W'(gain_ok ? gain_rd : '0);
  assign scaled   = 64'(prod >> 8);
  assign time_sat = (scaled > 64'({TIME_W{1'b1}})) ? '1 : scaled[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.hit_commit && hit_keep) begin
      time_mem[hit_slot] <= time_sat;
    end
    if (cmd.rd_issue) begin
      time_rd <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DETECTORS; i++) begin
        present[i] <= '0;
      end
    end else if (cmd.clr_present) begin
      for (int i = 0; i < NUM_DETECTORS; i++) begin
        present[i] <= '0;
      end
    end else if (cmd.hit_commit && hit_keep) begin
      present[hit_det] <= present[hit_det] | hit_onehot;
    end
  end

  // ---- scan counters and read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_d  <= '0;
      rd_c    <= '0;
      cap_vld <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_d <= '0;
      end else if (cmd.scan_next) begin
        scan_d <= scan_d + 1'b1;
      end
      if (cmd.rd_issue) begin
        rd_c <= stat.rd_end ? '0 : rd_c + 1'b1;
      end
      cap_vld <= cmd.rd_issue;
    end
  end

  assign rd_addr = SLOT_W'(int'(scan_d) * NUM_CHANNELS + int'(rd_c));

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      cap_idx <= rd_c;
    end
    if (cap_vld) begin
      tbuf[cap_idx] <= time_rd;
    end
  end

  assign mask_cur      = present[scan_d];
  assign stat.mask_nz  = mask_cur != '0;
  assign stat.scan_end = scan_d == DET_W'(SCAN_LAST);
  assign stat.rd_end   = rd_c == CH_IDX_W'(NUM_CHANNELS - 1);
  assign stat.out_free = !res_valid || !res_stall;

  // ---- result arithmetic, absent channels count as zero
  assign t_x1 = mask_cur[CH_X1] ? tbuf[CH_X1] : '0;
  assign t_x2 = mask_cur[CH_X2] ? tbuf[CH_X2] : '0;
  assign t_y1 = mask_cur[CH_Y1] ? tbuf[CH_Y1] : '0;
  assign t_y2 = mask_cur[CH_Y2] ? tbuf[CH_Y2] : '0;
  assign t_a  = mask_cur[CH_A]  ? tbuf[CH_A]  : '0;
  assign hx   = mask_cur[CH_X1] && mask_cur[CH_X2];
  assign hy   = mask_cur[CH_Y1] && mask_cur[CH_Y2];
  assign ha   = mask_cur[CH_A];

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      r_det    <= 5'(scan_d);
      r_mask   <= mask_cur;
      r_x1     <= t_x1;
      r_x2     <= t_x2;
      r_y1     <= t_y1;
      r_y2     <= t_y2;
      r_a      <= t_a;
      r_diff_x <= hx ? {1'b0, t_x1} - {1'b0, t_x2} : MISSING_33;
      r_diff_y <= hy ? {1'b0, t_y1} - {1'b0, t_y2} : MISSING_33;
      r_sum_x  <= (hx && ha) ? {2'b00, t_x1} + {2'b00, t_x2} - {1'b0, t_a, 1'b0}
                             : MISSING_34;
      r_sum_y  <= (hy && ha) ? {2'b00, t_y1} + {2'b00, t_y2} - {1'b0, t_a, 1'b0}
                             : MISSING_34;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_det      <= r_det;
      present_mask <= r_mask;
      time_x1      <= r_x1;
      time_x2      <= r_x2;
      time_y1      <= r_y1;
      time_y2      <= r_y2;
      time_anode   <= r_a;
      diff_x       <= $signed(r_diff_x);
      sum_x        <= $signed(r_sum_x);
      diff_y       <= $signed(r_diff_y);
      sum_y        <= $signed(r_sum_y);
      last         <= cmd.out_last;
    end
  end

endmodule

// ----- rtl/core/ppac_tdc_hit_event_builder.sv -----
// ----------------------------------------------------------------------------
// ppac_tdc_hit_event_builder
// collects calibrated tdc hits per detector and emits one word per detector
// with hits at end of event
// ----------------------------------------------------------------------------
//  channel   handshake              word
//  request   req_valid / req_stall  req_type det_id channel raw_time
//                                   table_word table_value
//  result    res_valid / res_stall  out_det present_mask time_* diff_* sum_*
//                                   last
//
//  a table write is stored when taken; a hit goes through a gain read, then
//  multiply and store; end of event holds requests off while it visits every
//  detector and, per detector with hits, makes five reads of the single time
//  memory read port, a drain, a result step and a hand-over
//  reset is synchronous; windows, present bits and gain valid bits clear at once
//  a stalled result word holds the scan; the block takes new requests as soon
//  as the last word of an event sits in the output register
// ----------------------------------------------------------------------------
module ppac_tdc_hit_event_builder
  import pteb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic [4:0]         det_id,
  input  logic [2:0]         channel,
  input  logic [15:0]        raw_time,
  input  logic [2:0]         table_word,
  input  logic [23:0]        table_value,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic [4:0]         out_det,
  output logic [4:0]         present_mask,
  output logic [31:0]        time_x1,
  output logic [31:0]        time_x2,
  output logic [31:0]        time_y1,
  output logic [31:0]        time_y2,
  output logic [31:0]        time_anode,
  output logic signed [32:0] diff_x,
  output logic signed [33:0] sum_x,
  output logic signed [32:0] diff_y,
  output logic signed [33:0] sum_y,
  output logic               last
);

  // commands down, status up
  pteb_cmd_t  cmd;
  pteb_stat_t stat;

  // sequencer: request acceptance, hit commit, scan and hand-over
  pteb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, hit store, multiplier, result arithmetic, output register
  pteb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .det_id       (det_id),
    .channel      (channel),
    .raw_time     (raw_time),
    .table_word   (table_word),
    .table_value  (table_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_det      (out_det),
    .present_mask (present_mask),
    .time_x1      (time_x1),
    .time_x2      (time_x2),
    .time_y1      (time_y1),
    .time_y2      (time_y2),
    .time_anode   (time_anode),
    .diff_x       (diff_x),
    .sum_x        (sum_x),
    .diff_y       (diff_y),
    .sum_y        (sum_y),
    .last         (last)
  );

endmodule

// ----- rtl/core/pteb_chk.sv -----
// ----------------------------------------------------------------------------
// pteb_chk
// port-level checks of the tdc hit event builder, bound to the top level
// ----------------------------------------------------------------------------
module pteb_chk
  import pteb_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic [1:0]         req_type,
  input logic               res_valid,
  input logic               res_stall,
  input logic [4:0]         out_det,
  input logic [4:0]         present_mask,
  input logic signed [32:0] diff_x,
  input logic               last
);

  // a held result word keeps its detector and last flag
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_det) && $stable(last))
    else $error("result word changed while stalled");

  // an accepted hit holds off further requests while its read-modify-write commits
  a_hit_two_cycles: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_type == REQ_HIT |=> req_stall)
    else $error("request taken during hit commit");

  // a new result word is only loaded while requests are held off
  a_res_in_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result word appeared outside the scan");

  // no result for a detector without hits
  a_res_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> present_mask != 5'd0)
    else $error("result word with empty present mask");

  // x difference carries the marker unless both x channels are present
  a_diff_x_mark: assert property (@(posedge clk) disable iff (rst)
    res_valid && !(present_mask[0] && present_mask[1]) |-> diff_x == -33'sd99999)
    else $error("x difference without marker");

endmodule

bind ppac_tdc_hit_event_builder pteb_chk u_pteb_chk (.*);

// ----- sim/hit_event_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_event_scoreboard
// request and result word types plus a scoreboard that keeps its own copy of
// the windows, gains and hit store, predicts the detector words of each end
// of event and compares every result word with the oldest one still pending
// ----------------------------------------------------------------------------
package hit_event_sb_pkg;
  import pteb_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  det;
    logic [2:0]  chan;
    logic [15:0] raw;
    logic [2:0]  word;
    logic [23:0] value;
  } tdc_request_t;

  typedef struct {
    logic [4:0]         det;
    logic [4:0]         mask;
    logic [31:0]        t [NUM_CHANNELS];
    logic signed [32:0] diff_x;
    logic signed [33:0] sum_x;
    logic signed [32:0] diff_y;
    logic signed [33:0] sum_y;
    logic               last;
  } det_result_t;

  class hit_event_scoreboard;
    logic [TIME_W-1:0]   hit_ns [NUM_DETECTORS][NUM_CHANNELS];
    logic [4:0]          slot_mask [NUM_DETECTORS];
    logic [RAW_BITS-1:0] win_lo [NUM_DETECTORS];
    logic [RAW_BITS-1:0] win_hi [NUM_DETECTORS];
    logic [GAIN_W-1:0]   gain [NUM_DETECTORS][NUM_CHANNELS];
    det_result_t         expected_words [$];
    string               time_names [NUM_CHANNELS];
    int                  errors;

    function new();
      for (int d = 0; d < NUM_DETECTORS; d++) begin
        slot_mask[d] = '0;
        win_lo[d]    = '0;
        win_hi[d]    = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          hit_ns[d][c] = '0;
          gain[d][c]   = '0;
        end
      end
      time_names = '{"time_x1", "time_x2", "time_y1", "time_y2", "time_anode"};
      errors = 0;
    endfunction

    // raw count times q8.16 gain, kept with 8 fraction bits, saturating
    function logic [TIME_W-1:0] scaled_ns(logic [RAW_BITS-1:0] raw, logic [GAIN_W-1:0] g);
      logic [63:0] p;
      p = (64'(raw) * 64'(g)) >> 8;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function void note_request(tdc_request_t r);
      logic [RAW_BITS-1:0] raw;
      int                  d;
      int                  c;
      det_result_t         w;
      det_result_t         words [$];
      longint              t [NUM_CHANNELS];
      logic                hx, hy, ha;
      d   = int'(r.det);
      raw = r.raw[RAW_BITS-1:0];
      case (r.kind)
        REQ_HIT: begin
          if (d < NUM_DETECTORS && r.chan < NUM_CHANNELS) begin
            c = int'(r.chan);
            if (raw > win_lo[d] && raw < win_hi[d] && !slot_mask[d][c]) begin
              hit_ns[d][c]    = scaled_ns(raw, gain[d][c]);
              slot_mask[d][c] = 1'b1;
            end
          end
        end
        REQ_TABLE: begin
          if (d < NUM_DETECTORS) begin
            if (r.word == TW_LOW)
              win_lo[d] = r.value[RAW_BITS-1:0];
            else if (r.word == TW_HIGH)
              win_hi[d] = r.value[RAW_BITS-1:0];
            else if (r.word >= TW_GAIN_X1 && r.word <= TW_GAIN_LAST)
              gain[d][int'(r.word - TW_GAIN_X1)] = r.value;
          end
        end
        REQ_EOE: begin
          for (int k = 0; k < NUM_DETECTORS && k < 32; k++) begin
            if (slot_mask[k] != '0) begin
              for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                t[ch]   = slot_mask[k][ch] ? longint'(hit_ns[k][ch]) : 64'sd0;
                w.t[ch] = t[ch][31:0];
              end
              hx = slot_mask[k][CH_X1] & slot_mask[k][CH_X2];
              hy = slot_mask[k][CH_Y1] & slot_mask[k][CH_Y2];
              ha = slot_mask[k][CH_A];
              w.det    = 5'(k);
              w.mask   = slot_mask[k];
              w.diff_x = hx ? 33'(t[CH_X1] - t[CH_X2]) : MISSING_33;
              w.sum_x  = (hx && ha) ? 34'(t[CH_X1] + t[CH_X2] - 2 * t[CH_A]) : MISSING_34;
              w.diff_y = hy ? 33'(t[CH_Y1] - t[CH_Y2]) : MISSING_33;
              w.sum_y  = (hy && ha) ? 34'(t[CH_Y1] + t[CH_Y2] - 2 * t[CH_A]) : MISSING_34;
              w.last   = 1'b0;
              words = {words, w};
            end
          end
          if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
          foreach (words[i])
            expected_words = {expected_words, words[i]};
          for (int k = 0; k < NUM_DETECTORS; k++)
            slot_mask[k] = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(det_result_t got);
      det_result_t want;
      if (expected_words.size() == 0) begin
        $error("result word for detector %0d with nothing pending", got.det);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      check_field("out_det", want.det, got.det);
      check_field("present_mask", want.mask, got.mask);
      for (int c = 0; c < NUM_CHANNELS; c++)
        check_field(time_names[c], want.t[c], got.t[c]);
      check_field("diff_x", 64'(want.diff_x), 64'(got.diff_x));
      check_field("sum_x", 64'(want.sum_x), 64'(got.sum_x));
      check_field("diff_y", 64'(want.diff_y), 64'(got.diff_y));
      check_field("sum_y", 64'(want.sum_y), 64'(got.sum_y));
      check_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

// ----- sim/ppac_tdc_hit_event_builder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppac_tdc_hit_event_builder_tb
// drives table writes, hits and end-of-event requests into the event builder
// and checks every detector word against the scoreboard's own prediction,
// with bursty requests and a wandering stall pattern on the result side
// ----------------------------------------------------------------------------
module ppac_tdc_hit_event_builder_tb;
  import pteb_pkg::*;
  import hit_event_sb_pkg::*;

  // codes the package leaves unnamed, used only as noise
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] TW_UNUSED  = 3'd7;

  // stimulus volume and run limits
  localparam int LIVE_ITEMS   = 320;
  localparam int CYCLE_LIMIT  = 600000;
  // a full scan with every detector holding hits, plus some slack
  localparam int DRAIN_CYCLES = NUM_DETECTORS + 9 * NUM_DETECTORS + 64;

  // clock, reset and all block inputs start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        req_valid   = 1'b0;
  logic        req_stall;
  logic [1:0]  req_type    = REQ_HIT;
  logic [4:0]  det_id      = '0;
  logic [2:0]  channel     = CH_X1;
  logic [15:0] raw_time    = '0;
  logic [2:0]  table_word  = TW_LOW;
  logic [23:0] table_value = '0;

  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [4:0]         out_det;
  logic [4:0]         present_mask;
  logic [31:0]        time_x1;
  logic [31:0]        time_x2;
  logic [31:0]        time_y1;
  logic [31:0]        time_y2;
  logic [31:0]        time_anode;
  logic signed [32:0] diff_x;
  logic signed [33:0] sum_x;
  logic signed [32:0] diff_y;
  logic signed [33:0] sum_y;
  logic               last;

  ppac_tdc_hit_event_builder dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .det_id       (det_id),
    .channel      (channel),
    .raw_time     (raw_time),
    .table_word   (table_word),
    .table_value  (table_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_det      (out_det),
    .present_mask (present_mask),
    .time_x1      (time_x1),
    .time_x2      (time_x2),
    .time_y1      (time_y1),
    .time_y2      (time_y2),
    .time_anode   (time_anode),
    .diff_x       (diff_x),
    .sum_x        (sum_x),
    .diff_y       (diff_y),
    .sum_y        (sum_y),
    .last         (last)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hit_event_scoreboard sb;

  int cycle_count = 0;
  int burst_left  = 0;
  int live_count  = 0;
  int stall_mode  = 0;
  int stall_run   = 0;

  // windows as the stimulus last wrote them, so hits can be aimed inside
  logic [RAW_BITS-1:0] plan_lo [NUM_DETECTORS];
  logic [RAW_BITS-1:0] plan_hi [NUM_DETECTORS];

  tdc_request_t seen_req;
  det_result_t  seen_res;

  // ---------------------------------------------------------------------------
  // monitors: both sample the values standing just before the edge, so the
  // order against the block's own flops within the step does not matter
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      seen_req.kind  = req_type;
      seen_req.det   = det_id;
      seen_req.chan  = channel;
      seen_req.raw   = raw_time;
      seen_req.word  = table_word;
      seen_req.value = table_value;
      sb.note_request(seen_req);
    end
    if (!rst && res_valid && !res_stall) begin
      seen_res.det    = out_det;
      seen_res.mask   = present_mask;
      seen_res.t      = '{time_x1, time_x2, time_y1, time_y2, time_anode};
      seen_res.diff_x = diff_x;
      seen_res.sum_x  = sum_x;
      seen_res.diff_y = diff_y;
      seen_res.sum_y  = sum_y;
      seen_res.last   = last;
      sb.check_result(seen_res);
    end
  end

  // ---------------------------------------------------------------------------
  // result side back-pressure: a mode held for a random stretch, ranging
  // from no stall at all through light, heavy and blocky stalling
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(16, 96);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 2) == 0);
      2: res_stall <= ($urandom_range(0, 7) != 0);
      default: res_stall <= stall_run[3];
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ppac_tdc_hit_event_builder_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // all fields random, so unused fields toggle too; callers overwrite the rest
  function automatic tdc_request_t junk_word();
    tdc_request_t r;
    r.kind  = 2'($urandom);
    r.det   = 5'($urandom);
    r.chan  = 3'($urandom);
    r.raw   = 16'($urandom);
    r.word  = 3'($urandom);
    r.value = 24'($urandom);
    return r;
  endfunction

  // presents one word and returns at the edge that takes it; between bursts
  // the valid drops for a random gap or stays high (never lowered and raised in one step)
  task automatic send_word(tdc_request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    req_valid   <= 1'b1;
    req_type    <= r.kind;
    det_id      <= r.det;
    channel     <= r.chan;
    raw_time    <= r.raw;
    table_word  <= r.word;
    table_value <= r.value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic table_write(int d, logic [2:0] word, logic [23:0] value);
    tdc_request_t r;
    r       = junk_word();
    r.kind  = REQ_TABLE;
    r.det   = 5'(d);
    r.word  = word;
    r.value = value;
    if (word == TW_LOW)
      plan_lo[d] = value[RAW_BITS-1:0];
    else if (word == TW_HIGH)
      plan_hi[d] = value[RAW_BITS-1:0];
    send_word(r);
    live_count++;
  endtask

  task automatic hit(int d, logic [2:0] ch, logic [15:0] raw);
    tdc_request_t r;
    r      = junk_word();
    r.kind = REQ_HIT;
    r.det  = 5'(d);
    r.chan = ch;
    r.raw  = raw;
    send_word(r);
    live_count++;
  endtask

  task automatic end_event();
    tdc_request_t r;
    r      = junk_word();
    r.kind = REQ_EOE;
    send_word(r);
    live_count++;
  endtask

  // words the block must ignore: unknown request, bad channel, bad table word
  task automatic noise();
    tdc_request_t r;
    r = junk_word();
    case ($urandom_range(0, 2))
      0: r.kind = REQ_UNUSED;
      1: begin
        r.kind = REQ_HIT;
        r.chan = 3'($urandom_range(NUM_CHANNELS, 7));
      end
      default: begin
        r.kind = REQ_TABLE;
        r.word = TW_UNUSED;
      end
    endcase
    send_word(r);
  endtask

  // mostly strictly inside the window, otherwise on its edges or anywhere
  function automatic logic [15:0] pick_raw(int d);
    int lo, hi;
    lo = int'(plan_lo[d]);
    hi = int'(plan_hi[d]);
    if (hi > lo + 1 && $urandom_range(0, 9) < 8)
      return 16'($urandom_range(lo + 1, hi - 1));
    case ($urandom_range(0, 2))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom);
    endcase
  endfunction

  // new window and some gains for one detector; upper value bits are junk
  task automatic retune(int d);
    int lo, hi;
    case ($urandom_range(0, 9))
      0, 1: begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
      end
      2: begin
        lo = $urandom_range(0, 65000);
        hi = lo + $urandom_range(0, 3);
      end
      default: begin
        lo = $urandom_range(0, 3000);
        hi = $urandom_range(40000, 65535);
      end
    endcase
    table_write(d, TW_LOW, {8'($urandom), 16'(lo)});
    table_write(d, TW_HIGH, {8'($urandom), 16'(hi)});
    for (int g = TW_GAIN_X1; g <= TW_GAIN_LAST; g++)
      if ($urandom_range(0, 1) == 1)
        table_write(d, 3'(g), ($urandom_range(0, 1) == 1) ? 24'($urandom) :
                                                             24'($urandom_range(0, 1023)));
  endtask

  // one event: a few detectors (or all of them, one hit each) then the end
  task automatic run_event(bit every_det);
    int n_det, d, n_hits;
    n_det = every_det ? NUM_DETECTORS : $urandom_range(0, 5);
    for (int i = 0; i < n_det; i++) begin
      d = every_det ? i : $urandom_range(0, NUM_DETECTORS - 1);
      if (!every_det && $urandom_range(0, 3) == 0)
        retune(d);
      n_hits = every_det ? 1 : $urandom_range(1, 7);
      for (int h = 0; h < n_hits; h++) begin
        hit(d, 3'($urandom_range(0, NUM_CHANNELS - 1)), pick_raw(d));
        if ($urandom_range(0, 19) == 0)
          noise();
      end
    end
    end_event();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb = new();
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      plan_lo[d] = '0;
      plan_hi[d] = '0;
    end

    // synchronous reset at the start, once
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // -- directed part --
    // empty event gives nothing back
    end_event();
    // windows still zero after reset, so this hit is dropped
    hit(0, CH_X1, 16'd0);
    // widest window and extreme gains on the top detector; the upper limit
    // is written with all 24 bits set and keeps only the count bits
    table_write(NUM_DETECTORS - 1, TW_LOW, 24'd0);
    table_write(NUM_DETECTORS - 1, TW_HIGH, 24'hFF_FFFF);
    table_write(NUM_DETECTORS - 1, TW_GAIN_X1, 24'hFF_FFFF);
    table_write(NUM_DETECTORS - 1, TW_GAIN_X1 + 3'd1, 24'h00_0000);
    table_write(NUM_DETECTORS - 1, TW_GAIN_X1 + 3'd2, 24'h00_0001);
    table_write(NUM_DETECTORS - 1, TW_GAIN_X1 + 3'd3, 24'h80_0000);
    table_write(NUM_DETECTORS - 1, TW_GAIN_LAST, 24'hFF_FFFF);
    // unknown table word and unknown request, both ignored
    begin
      tdc_request_t r;
      r       = junk_word();
      r.kind  = REQ_TABLE;
      r.det   = 5'(NUM_DETECTORS - 1);
      r.word  = TW_UNUSED;
      r.value = 24'd0;
      send_word(r);
      r       = junk_word();
      r.kind  = REQ_UNUSED;
      send_word(r);
    end
    // all five channels of the top detector, mostly at the extremes of the count
    hit(NUM_DETECTORS - 1, CH_X1, 16'hFFFE);
    hit(NUM_DETECTORS - 1, CH_X2, 16'h0001);
    hit(NUM_DETECTORS - 1, CH_Y1, 16'hFFFE);
    hit(NUM_DETECTORS - 1, CH_Y2, 16'h8000);
    hit(NUM_DETECTORS - 1, CH_A, 16'h0001);
    // unknown channel, then a repeated hit on a taken slot
    begin
      tdc_request_t r;
      r      = junk_word();
      r.kind = REQ_HIT;
      r.det  = 5'(NUM_DETECTORS - 1);
      r.chan = 3'd7;
      r.raw  = 16'h1234;
      send_word(r);
    end
    hit(NUM_DETECTORS - 1, CH_X1, 16'd5);
    // narrow window on detector 0: both limits are outside, one value inside
    table_write(0, TW_LOW, 24'd10);
    table_write(0, TW_HIGH, 24'd20);
    hit(0, CH_X1, 16'd10);
    hit(0, CH_X1, 16'd20);
    hit(0, CH_X1, 16'd11);
    end_event();

    // -- random part --
    // give every detector a window first so full-width events find hits
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      table_write(d, TW_LOW, {8'($urandom), 16'($urandom_range(0, 4000))});
      table_write(d, TW_HIGH, {8'($urandom), 16'($urandom_range(30000, 65535))});
    end
    while (live_count < LIVE_ITEMS)
      run_event($urandom_range(0, 9) == 0);
    req_valid <= 1'b0;

    // let every pending word come out, then watch a while for strays
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("ppac_tdc_hit_event_builder_tb: PASS");
    else
      $display("ppac_tdc_hit_event_builder_tb: FAIL");
    $finish;
  end

endmodule
